// ===== rtl/qmc_pkg.sv =====
// ----------------------------------------------------------------------------
// qmc_pkg
// Shared types and constants of the quadrature motor position/speed control.
// ----------------------------------------------------------------------------
package qmc_pkg;

    // Kind of request carried in tuser
    typedef enum logic [2:0] {
        CMD_SAMPLE    = 3'd0,
        CMD_TICK      = 3'd1,
        CMD_DIR       = 3'd2,
        CMD_DIR_SPEED = 3'd3,
        CMD_POS       = 3'd4,
        CMD_POS_SPEED = 3'd5,
        CMD_CLEAR     = 3'd6,
        CMD_NONE      = 3'd7
    } t_cmd;

    // Stored drive direction
    typedef enum logic [1:0] {
        DIR_STOP = 2'd0,
        DIR_CW   = 2'd1,
        DIR_CCW  = 2'd2
    } t_dir;

    localparam logic [7:0] DIR_CODE_CW  = 8'd1;
    localparam logic [7:0] DIR_CODE_CCW = 8'd2;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_DUTY_MIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DUTY_MAX = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEADBAND = 2'd2;

    localparam int DEADBAND_RST = 10;

    // Fixed field widths and the input tdata layout
    localparam int TARGET_W  = 16;
    localparam int S_TDATA_W = 40;
    localparam int PA_BIT    = 0;
    localparam int PB_BIT    = 1;
    localparam int DIR_LSB   = 2;
    localparam int SPD_LSB   = 10;
    localparam int TGT_LSB   = 18;

    // floor(m / 255) == (m * RECIP_255) >> RECIP_SHIFT for every m below 2**16
    localparam int          RECIP_W     = 17;
    localparam int          RECIP_SHIFT = 24;
    localparam logic [16:0] RECIP_255   = 17'd65794;

endpackage

// ===== rtl/qmc_scale.sv =====
// ----------------------------------------------------------------------------
// qmc_scale
// Speed byte to duty scaling: holds the per-step coefficient derived from
// the duty limits and maps a speed byte into the duty range with saturation.
// ----------------------------------------------------------------------------
module qmc_scale
    import qmc_pkg::*;
#(
    parameter int DUTY_WIDTH = 10
) (
    input  logic                  i_clk,
    input  logic [DUTY_WIDTH-1:0] i_next_min,   // limits as they stand next cycle
    input  logic [DUTY_WIDTH-1:0] i_next_max,
    input  logic [DUTY_WIDTH-1:0] i_duty_min,   // current lower limit
    input  logic [7:0]            i_speed,
    output logic [DUTY_WIDTH-1:0] o_level
);

    localparam int PW = DUTY_WIDTH + RECIP_W;
    localparam int SW = DUTY_WIDTH + 10;

    logic signed [DUTY_WIDTH:0]   w_diff;
    logic [DUTY_WIDTH-1:0]        w_mag;
    logic [PW-1:0]                w_prod;
    logic [PW-1:0]                w_quo;
    logic signed [DUTY_WIDTH:0]   n_coe;
    logic signed [DUTY_WIDTH:0]   r_coe;
    logic signed [SW-1:0]         w_scaled;

    // coefficient = (max - min) / 255, truncating toward zero
    always_comb begin
        w_diff = $signed({1'b0, i_next_max}) - $signed({1'b0, i_next_min});
        w_mag  = w_diff[DUTY_WIDTH] ? DUTY_WIDTH'(-w_diff) : w_diff[DUTY_WIDTH-1:0];
        w_prod = PW'(w_mag) * PW'(RECIP_255);
        w_quo  = w_prod >> RECIP_SHIFT;
        n_coe  = w_diff[DUTY_WIDTH] ? -$signed({1'b0, w_quo[DUTY_WIDTH-1:0]})
                                    :  $signed({1'b0, w_quo[DUTY_WIDTH-1:0]});
    end

    always_ff @(posedge i_clk) begin
        r_coe <= n_coe;
    end

    always_comb begin
        w_scaled = SW'($signed({1'b0, i_speed})) * SW'(r_coe)
                 + SW'($signed({1'b0, i_duty_min}));
        if (w_scaled[SW-1]) begin
            o_level = '0;
        end else if (|w_scaled[SW-2:DUTY_WIDTH]) begin
            o_level = '1;
        end else begin
            o_level = w_scaled[DUTY_WIDTH-1:0];
        end
    end

endmodule

// ===== rtl/qmc_core.sv =====
// ----------------------------------------------------------------------------
// qmc_core
// Controller state and its single-pass update: quadrature counting, mode and
// drive commands, and the speed / position control tick.
// ----------------------------------------------------------------------------
module qmc_core
    import qmc_pkg::*;
#(
    parameter int COUNT_WIDTH = 16,
    parameter int DUTY_WIDTH  = 10
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_fire,
    input  t_cmd                          i_cmd,
    input  logic                          i_phase_a,
    input  logic                          i_phase_b,
    input  logic [7:0]                    i_direction,
    input  logic signed [TARGET_W-1:0]    i_target,
    input  logic [DUTY_WIDTH-1:0]         i_scaled,
    input  logic [DUTY_WIDTH-1:0]         i_duty_min,
    input  logic [DUTY_WIDTH-1:0]         i_duty_max,
    input  logic [DUTY_WIDTH-1:0]         i_deadband,
    output logic [DUTY_WIDTH-1:0]         o_duty_one,
    output logic [DUTY_WIDTH-1:0]         o_duty_two,
    output logic [COUNT_WIDTH-1:0]        o_count
);

    localparam int CMP_W = (COUNT_WIDTH + 1 > DUTY_WIDTH) ? COUNT_WIDTH + 1 : DUTY_WIDTH;

    logic [1:0]             r_last,   n_last;
    logic [COUNT_WIDTH-1:0] r_count,  n_count;
    logic [COUNT_WIDTH-1:0] r_target, n_target;
    logic                   r_pos_mode, n_pos_mode;
    t_dir                   r_dir,    n_dir;
    logic [DUTY_WIDTH-1:0]  r_level,  n_level;
    logic [DUTY_WIDTH-1:0]  r_duty_one, n_duty_one;
    logic [DUTY_WIDTH-1:0]  r_duty_two, n_duty_two;

    logic [1:0]                   w_phase_diff;
    logic                         w_up;
    logic signed [COUNT_WIDTH:0]  w_err;
    logic [COUNT_WIDTH-1:0]       w_err_mag;
    logic                         w_outside;
    logic                         w_ahead;
    t_dir                         w_dir_dec;
    logic [COUNT_WIDTH-1:0]       w_new_target;

    always_comb begin
        // quadrature step; phase A takes precedence when both moved
        w_phase_diff = {i_phase_a, i_phase_b} ^ r_last;
        if (w_phase_diff[1]) begin
            w_up = i_phase_a ? i_phase_b : !i_phase_b;
        end else begin
            w_up = i_phase_b ? !i_phase_a : i_phase_a;
        end

        // exact position error, one bit wider than the count
        w_err     = (COUNT_WIDTH + 1)'($signed(r_target)) - (COUNT_WIDTH + 1)'($signed(r_count));
        w_err_mag = w_err[COUNT_WIDTH] ? COUNT_WIDTH'(-w_err) : w_err[COUNT_WIDTH-1:0];
        w_outside = CMP_W'(w_err_mag) > CMP_W'(i_deadband);
        w_ahead   = !w_err[COUNT_WIDTH] && (w_err != '0);

        if (i_direction == DIR_CODE_CW) begin
            w_dir_dec = DIR_CW;
        end else if (i_direction == DIR_CODE_CCW) begin
            w_dir_dec = DIR_CCW;
        end else begin
            w_dir_dec = DIR_STOP;
        end
        w_new_target = COUNT_WIDTH'(i_target);
    end

    always_comb begin
        n_last     = r_last;
        n_count    = r_count;
        n_target   = r_target;
        n_pos_mode = r_pos_mode;
        n_dir      = r_dir;
        n_level    = r_level;
        n_duty_one = r_duty_one;
        n_duty_two = r_duty_two;
        unique case (i_cmd)
            CMD_SAMPLE: begin
                n_last = {i_phase_a, i_phase_b};
                if (|w_phase_diff) begin
                    n_count = w_up ? r_count + COUNT_WIDTH'(1) : r_count - COUNT_WIDTH'(1);
                end
            end
            CMD_TICK: begin
                n_duty_one = i_duty_min;
                n_duty_two = i_duty_min;
                if (!r_pos_mode) begin
                    unique case (r_dir)
                        DIR_CW:  n_duty_one = r_level;
                        DIR_CCW: n_duty_two = r_level;
                        default: ;
                    endcase
                end else if (w_outside) begin
                    if (w_ahead) begin
                        n_duty_two = r_level;
                    end else begin
                        n_duty_one = r_level;
                    end
                end else begin
                    // inside the deadband: snap to target
                    n_count = r_target;
                end
            end
            CMD_DIR: begin
                n_pos_mode = 1'b0;
                n_dir      = w_dir_dec;
                n_level    = i_duty_max;
            end
            CMD_DIR_SPEED: begin
                n_pos_mode = 1'b0;
                n_dir      = w_dir_dec;
                n_level    = i_scaled;
            end
            CMD_POS: begin
                n_pos_mode = 1'b1;
                n_target   = w_new_target;
                n_level    = i_duty_max;
            end
            CMD_POS_SPEED: begin
                n_pos_mode = 1'b1;
                n_target   = w_new_target;
                n_level    = i_scaled;
            end
            CMD_CLEAR: begin
                n_count  = '0;
                n_target = '0;
            end
            CMD_NONE: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last     <= '0;
            r_count    <= '0;
            r_target   <= '0;
            r_pos_mode <= 1'b0;
            r_dir      <= DIR_STOP;
            r_level    <= '0;
            r_duty_one <= '0;
            r_duty_two <= '0;
        end else if (i_fire) begin
            r_last     <= n_last;
            r_count    <= n_count;
            r_target   <= n_target;
            r_pos_mode <= n_pos_mode;
            r_dir      <= n_dir;
            r_level    <= n_level;
            r_duty_one <= n_duty_one;
            r_duty_two <= n_duty_two;
        end
    end

    assign o_duty_one = n_duty_one;
    assign o_duty_two = n_duty_two;
    assign o_count    = n_count;

endmodule

// ===== rtl/quadrature_motor_position_speed_control.sv =====
// ----------------------------------------------------------------------------
// quadrature_motor_position_speed_control
// Quadrature encoder counter and H-bridge duty controller, stream in / out.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on the i_s_* stream: tuser carries the kind (encoder
//   sample, control tick, direction, direction+speed, position,
//   position+speed, clear), tdata the phase levels, direction, speed byte
//   and target. Every request yields exactly one result on the o_m_* stream
//   carrying both bridge duties and the position count after the request.
//   A request goes into the input register, then through one pass of update
//   logic into the result register. One request is taken every cycle while
//   the receiver keeps up; the rate is set by that single-pass update, and
//   the input register can take one more while a finished result waits.
//   When the receiver stalls, the result holds, the next request waits in the
//   input register and tready drops only once both registers are full.
//   The config channel writes duty_min, duty_max and deadband (index 0..2,
//   others dropped) and is always ready; the user must write it only while
//   idle (the block does not enforce it). Reset (synchronous, active low)
//   clears all state, empties both registers, restores duty_min 0, duty_max full scale, deadband 10.
// ----------------------------------------------------------------------------
module quadrature_motor_position_speed_control
    import qmc_pkg::*;
#(
    parameter int COUNT_WIDTH = 16,
    parameter int DUTY_WIDTH  = 10
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // request stream
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    // tdata: phase_a[0], phase_b[1], direction[9:2], speed[17:10], target[33:18]
    input  logic [S_TDATA_W-1:0]   i_s_tdata,
    // tuser: cmd[2:0]
    input  logic [2:0]             i_s_tuser,
    // result stream
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    // tdata: duty_one, duty_two, count, from the lowest bit up, zero padded
    output logic [((2*DUTY_WIDTH+COUNT_WIDTH+7)/8)*8-1:0] o_m_tdata,
    // configuration writes
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [DUTY_WIDTH-1:0]  i_cfg_data
);

    localparam int M_TDATA_W = ((2*DUTY_WIDTH+COUNT_WIDTH+7)/8)*8;

    // configuration
    logic [DUTY_WIDTH-1:0] r_duty_min, n_duty_min;
    logic [DUTY_WIDTH-1:0] r_duty_max, n_duty_max;
    logic [DUTY_WIDTH-1:0] r_deadband, n_deadband;

    // input register
    logic                        r_in_valid;
    t_cmd                        r_in_cmd;
    logic                        r_in_phase_a;
    logic                        r_in_phase_b;
    logic [7:0]                  r_in_direction;
    logic [7:0]                  r_in_speed;
    logic signed [TARGET_W-1:0]  r_in_target;

    // result register
    logic                        r_out_valid;
    logic [DUTY_WIDTH-1:0]       r_out_duty_one;
    logic [DUTY_WIDTH-1:0]       r_out_duty_two;
    logic [COUNT_WIDTH-1:0]      r_out_count;

    logic                        w_out_free;
    logic                        w_fire;
    logic [DUTY_WIDTH-1:0]       w_scaled;
    logic [DUTY_WIDTH-1:0]       w_duty_one;
    logic [DUTY_WIDTH-1:0]       w_duty_two;
    logic [COUNT_WIDTH-1:0]      w_count;

    // ------------------------------------------------------------------
    // Configuration: always ready; next values also feed the coefficient
    // register so it is loaded in step with the limit registers.
    // ------------------------------------------------------------------
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_duty_min = r_duty_min;
        n_duty_max = r_duty_max;
        n_deadband = r_deadband;
        if (!i_rst_n) begin
            n_duty_min = '0;
            n_duty_max = '1;
            n_deadband = DUTY_WIDTH'(DEADBAND_RST);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_DUTY_MIN: n_duty_min = i_cfg_data;
                REG_DUTY_MAX: n_duty_max = i_cfg_data;
                REG_DEADBAND: n_deadband = i_cfg_data;
                default:      ;   // writes beyond the register list are dropped
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_duty_min <= n_duty_min;
        r_duty_max <= n_duty_max;
        r_deadband <= n_deadband;
    end

    // ------------------------------------------------------------------
    // Flow control: the update fires when the input register holds a
    // request and the result register is empty or being drained.
    // ------------------------------------------------------------------
    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_fire     = r_in_valid && w_out_free;
    assign o_s_tready = !r_in_valid || w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    // capture payload on acceptance
    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_cmd       <= t_cmd'(i_s_tuser);
            r_in_phase_a   <= i_s_tdata[PA_BIT];
            r_in_phase_b   <= i_s_tdata[PB_BIT];
            r_in_direction <= i_s_tdata[DIR_LSB +: 8];
            r_in_speed     <= i_s_tdata[SPD_LSB +: 8];
            r_in_target    <= $signed(i_s_tdata[TGT_LSB +: TARGET_W]);
        end
    end

    // ------------------------------------------------------------------
    // Update logic
    // ------------------------------------------------------------------
    qmc_scale #(
        .DUTY_WIDTH (DUTY_WIDTH)
    ) u_scale (
        .i_clk      (i_clk),
        .i_next_min (n_duty_min),
        .i_next_max (n_duty_max),
        .i_duty_min (r_duty_min),
        .i_speed    (r_in_speed),
        .o_level    (w_scaled)
    );

    qmc_core #(
        .COUNT_WIDTH (COUNT_WIDTH),
        .DUTY_WIDTH  (DUTY_WIDTH)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (w_fire),
        .i_cmd       (r_in_cmd),
        .i_phase_a   (r_in_phase_a),
        .i_phase_b   (r_in_phase_b),
        .i_direction (r_in_direction),
        .i_target    (r_in_target),
        .i_scaled    (w_scaled),
        .i_duty_min  (r_duty_min),
        .i_duty_max  (r_duty_max),
        .i_deadband  (r_deadband),
        .o_duty_one  (w_duty_one),
        .o_duty_two  (w_duty_two),
        .o_count     (w_count)
    );

    // ------------------------------------------------------------------
    // Result register: load on fire, drop valid once taken.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_duty_one <= w_duty_one;
            r_out_duty_two <= w_duty_two;
            r_out_count    <= w_count;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = M_TDATA_W'({r_out_count, r_out_duty_two, r_out_duty_one});

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_clear_zeroes_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && r_in_cmd == CMD_CLEAR) |=> (r_out_count == '0))
        else $error("count not zero after clear request");

    a_full_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !i_m_tready) |-> (!o_s_tready && !w_fire))
        else $error("request taken while both registers full and stalled");

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_m_tvalid && o_s_tready))
        else $error("pipeline not empty after reset");

endmodule
